// ===== design/integral_image_adaptive_threshold_top_macros.svh =====
// Assertion macros shared by the adaptive threshold design.
`ifndef INTEGRAL_IMAGE_ADAPTIVE_THRESHOLD_TOP_MACROS_SVH
`define INTEGRAL_IMAGE_ADAPTIVE_THRESHOLD_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define IIAT_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("adaptive threshold: implication check failed");

// Next-cycle implication, checked out of reset.
`define IIAT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("adaptive threshold: next-cycle check failed");

`endif

// ===== design/iiat_pkg.sv =====
`default_nettype none

package iiat_pkg;

   localparam int PIX_BITS       = 8;
   localparam int PIX_CENTER     = 128;
   localparam int KERNEL_DEFAULT = 11;
   localparam int DIM_RESET      = 256;
   localparam int K_BITS         = 16;
   localparam int L_BITS         = 11;
   localparam int COORD_BITS     = 14;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 9;

   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KERNEL_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KERNEL_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COMPARE_MODE  = 3'd4;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic MODE_AT_OR_ABOVE = 1'b0;
   localparam logic MODE_AT_OR_BELOW = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [PIX_BITS-1:0] pixel;
      logic                frame_start;
      logic [7:0]          query_x;
      logic [7:0]          query_y;
   } req_type;

   typedef struct packed {
      logic bit_res;
      logic in_region;
   } rsp_type;

   typedef struct packed {
      logic [8:0] image_width;
      logic [8:0] image_height;
      logic [7:0] kernel_width;
      logic [7:0] kernel_height;
      logic       compare_mode;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_READ,
      ST_LOAD_WRITE,
      ST_QUERY_CHECK,
      ST_QUERY_READ1,
      ST_QUERY_READ2,
      ST_QUERY_READ3,
      ST_QUERY_READ4,
      ST_QUERY_MUL1,
      ST_QUERY_MUL2,
      ST_QUERY_DONE
   } state_type;

   typedef enum logic [1:0] {
      CORNER_BR,
      CORNER_TR,
      CORNER_BL,
      CORNER_TL
   } corner_type;

   typedef enum logic [1:0] {
      ACC_LOAD,
      ACC_SUB,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic       latch;
      logic       ld_read;
      logic       ld_write;
      logic       q_read;
      corner_type corner;
      logic       pix_read;
      logic       acc_en;
      acc_op_type acc_op;
      logic       mul1;
      logic       mul2;
      logic       emit;
      logic       emit_default;
   } ctrl_type;

   typedef struct packed {
      logic load_ok;
      logic in_region;
   } status_type;

endpackage

`default_nettype wire

// ===== design/iiat_csr.sv =====
`default_nettype none

module iiat_csr
   import iiat_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   cfg_in.image_width   = csr_wdata;
            CSR_IMAGE_HEIGHT:  cfg_in.image_height  = csr_wdata;
            CSR_KERNEL_WIDTH:  cfg_in.kernel_width  = csr_wdata[7:0];
            CSR_KERNEL_HEIGHT: cfg_in.kernel_height = csr_wdata[7:0];
            CSR_COMPARE_MODE:  cfg_in.compare_mode  = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= 9'(DIM_RESET);
         cfg_ff.image_height  <= 9'(DIM_RESET);
         cfg_ff.kernel_width  <= 8'(KERNEL_DEFAULT);
         cfg_ff.kernel_height <= 8'(KERNEL_DEFAULT);
         cfg_ff.compare_mode  <= MODE_AT_OR_ABOVE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/iiat_ctrl.sv =====
`default_nettype none

module iiat_ctrl
   import iiat_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic cmd,
   input  status_type status,
   output ctrl_type   ctrl,
   output logic       busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      ctrl.corner = CORNER_BR;
      ctrl.acc_op = ACC_LOAD;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.latch = 1'b1;
               state_in   = (cmd == CMD_QUERY) ? ST_QUERY_CHECK : ST_LOAD_READ;
            end
         end
         ST_LOAD_READ: begin
            if (status.load_ok) begin
               ctrl.ld_read = 1'b1;
               state_in     = ST_LOAD_WRITE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD_WRITE: begin
            ctrl.ld_write = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_QUERY_CHECK: begin
            if (status.in_region) begin
               ctrl.q_read   = 1'b1;
               ctrl.corner   = CORNER_BR;
               ctrl.pix_read = 1'b1;
               state_in      = ST_QUERY_READ1;
            end else begin
               ctrl.emit_default = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_QUERY_READ1: begin
            ctrl.q_read = 1'b1;
            ctrl.corner = CORNER_TR;
            ctrl.acc_en = 1'b1;
            ctrl.acc_op = ACC_LOAD;
            state_in    = ST_QUERY_READ2;
         end
         ST_QUERY_READ2: begin
            ctrl.q_read = 1'b1;
            ctrl.corner = CORNER_BL;
            ctrl.acc_en = 1'b1;
            ctrl.acc_op = ACC_SUB;
            state_in    = ST_QUERY_READ3;
         end
         ST_QUERY_READ3: begin
            ctrl.q_read = 1'b1;
            ctrl.corner = CORNER_TL;
            ctrl.acc_en = 1'b1;
            ctrl.acc_op = ACC_SUB;
            state_in    = ST_QUERY_READ4;
         end
         ST_QUERY_READ4: begin
            ctrl.acc_en = 1'b1;
            ctrl.acc_op = ACC_ADD;
            state_in    = ST_QUERY_MUL1;
         end
         ST_QUERY_MUL1: begin
            ctrl.mul1 = 1'b1;
            state_in  = ST_QUERY_MUL2;
         end
         ST_QUERY_MUL2: begin
            ctrl.mul2 = 1'b1;
            state_in  = ST_QUERY_DONE;
         end
         ST_QUERY_DONE: begin
            ctrl.emit = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== design/iiat_dp.sv =====
`default_nettype none

module iiat_dp
   import iiat_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   input  req_type   req_data,
   input  cfg_type   cfg,
   input  ctrl_type  ctrl,
   output status_type status,
   output logic      rsp_valid,
   output rsp_type   rsp_data
);

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int AW    = XW + YW;
   localparam int DEPTH = 1 << AW;
   localparam int SW    = AW + 9;
   localparam int RSW   = XW + 9;
   localparam int NW    = AW + 1;
   localparam int PW    = SW + NW + 18;
   localparam int CB    = COORD_BITS;

   // Effective dimensions after saturation.
   logic [XW:0] w_eff;
   logic [YW:0] h_eff;
   logic [7:0]  kw_eff;
   logic [7:0]  kh_eff;

   always_comb begin
      if (cfg.image_width == '0) begin
         w_eff = (XW+1)'(1);
      end else if (32'(cfg.image_width) > MAX_WIDTH) begin
         w_eff = (XW+1)'(MAX_WIDTH);
      end else begin
         w_eff = (XW+1)'(cfg.image_width);
      end
      if (cfg.image_height == '0) begin
         h_eff = (YW+1)'(1);
      end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
         h_eff = (YW+1)'(MAX_HEIGHT);
      end else begin
         h_eff = (YW+1)'(cfg.image_height);
      end
      kw_eff = (cfg.kernel_width == '0) ? 8'd1 : cfg.kernel_width;
      kh_eff = (cfg.kernel_height == '0) ? 8'd1 : cfg.kernel_height;
   end

   // Window area and frame area, registered ahead of the product stages.
   logic [K_BITS-1:0] k_ff;
   logic [NW-1:0]     n_ff;

   always_ff @(posedge clock) begin
      k_ff <= K_BITS'(kw_eff) * K_BITS'(kh_eff);
      n_ff <= NW'(w_eff) * NW'(h_eff);
   end

   // Request capture and raster position.
   req_type                 req_ff;
   logic [XW-1:0]           col_ff;
   logic [YW:0]             row_ff;
   logic signed [RSW-1:0]   rowsum_ff;
   logic signed [SW-1:0]    total_ff;
   logic signed [8:0]       delta;
   logic signed [RSW-1:0]   rowsum_new;
   logic [XW:0]             col_plus;

   assign delta      = 9'(req_ff.pixel) - 9'(PIX_CENTER);
   assign rowsum_new = rowsum_ff + RSW'(delta);
   assign col_plus   = (XW+1)'(col_ff) + (XW+1)'(1);

   always_ff @(posedge clock) begin
      if (ctrl.latch) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         rowsum_ff <= '0;
         total_ff  <= '0;
      end else if (ctrl.latch && req_data.cmd == CMD_LOAD && req_data.frame_start) begin
         col_ff    <= '0;
         row_ff    <= '0;
         rowsum_ff <= '0;
         total_ff  <= '0;
      end else if (ctrl.ld_write) begin
         total_ff <= total_ff + SW'(delta);
         if (col_plus >= w_eff) begin
            col_ff    <= '0;
            row_ff    <= row_ff + (YW+1)'(1);
            rowsum_ff <= '0;
         end else begin
            col_ff    <= col_plus[XW-1:0];
            rowsum_ff <= rowsum_new;
         end
      end
   end

   assign status.load_ok = (row_ff < h_eff) && ((XW+1)'(col_ff) < w_eff);

   // Window geometry in signed coordinates.
   logic signed [CB-1:0] one_c, qx_c, qy_c, kw_c, kh_c, hw_c, hh_c, w_c, h_c;
   logic signed [CB-1:0] x_c, y_c, lim_x, lim_y, top_r, bot_r, lft_c, rgt_c;

   assign one_c = CB'(1);
   assign qx_c  = CB'(req_ff.query_x);
   assign qy_c  = CB'(req_ff.query_y);
   assign kw_c  = CB'(kw_eff);
   assign kh_c  = CB'(kh_eff);
   assign hw_c  = CB'(kw_eff >> 1);
   assign hh_c  = CB'(kh_eff >> 1);
   assign w_c   = CB'(w_eff);
   assign h_c   = CB'(h_eff);
   assign x_c   = qx_c - hw_c;
   assign y_c   = qy_c - hh_c;
   assign lim_x = w_c - kw_c - one_c;
   assign lim_y = h_c - kh_c - one_c;
   assign top_r = y_c - one_c;
   assign bot_r = y_c + kh_c - one_c;
   assign lft_c = x_c - one_c;
   assign rgt_c = x_c + kw_c - one_c;

   assign status.in_region = (x_c >= one_c) && (y_c >= one_c) &&
                             (x_c <= lim_x) && (y_c <= lim_y);

   // Pixel store and summed-area table.
   logic [PIX_BITS-1:0] pix_mem [DEPTH];
   logic [SW-1:0]       area_mem [DEPTH];
   logic [AW-1:0]       wr_addr;
   logic [AW-1:0]       rd_addr;
   logic [AW-1:0]       pix_addr;
   logic [PIX_BITS-1:0] pix_rd_ff;
   logic signed [SW-1:0] area_rd_ff;
   logic signed [SW-1:0] area_wr;
   logic [YW-1:0]       row_above;

   assign wr_addr   = {row_ff[YW-1:0], col_ff};
   assign row_above = row_ff[YW-1:0] - YW'(1);
   assign pix_addr  = {qy_c[YW-1:0], qx_c[XW-1:0]};
   assign area_wr   = SW'(rowsum_new) + ((row_ff != '0) ? area_rd_ff : SW'(0));

   always_comb begin
      if (ctrl.ld_read) begin
         rd_addr = {row_above, col_ff};
      end else begin
         case (ctrl.corner)
            CORNER_BR: rd_addr = {bot_r[YW-1:0], rgt_c[XW-1:0]};
            CORNER_TR: rd_addr = {top_r[YW-1:0], rgt_c[XW-1:0]};
            CORNER_BL: rd_addr = {bot_r[YW-1:0], lft_c[XW-1:0]};
            CORNER_TL: rd_addr = {top_r[YW-1:0], lft_c[XW-1:0]};
            default:   rd_addr = {bot_r[YW-1:0], rgt_c[XW-1:0]};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_write) begin
         area_mem[wr_addr] <= area_wr;
         pix_mem[wr_addr]  <= req_ff.pixel;
      end
      if (ctrl.ld_read || ctrl.q_read) begin
         area_rd_ff <= area_mem[rd_addr];
      end
      if (ctrl.pix_read) begin
         pix_rd_ff <= pix_mem[pix_addr];
      end
   end

   // Window sum accumulation over the four corner reads.
   logic signed [SW-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (ctrl.acc_en) begin
         case (ctrl.acc_op)
            ACC_LOAD: acc_ff <= area_rd_ff;
            ACC_SUB:  acc_ff <= acc_ff - area_rd_ff;
            ACC_ADD:  acc_ff <= acc_ff + area_rd_ff;
            default:  acc_ff <= acc_ff;
         endcase
      end
   end

   // Exact compare of l*K*N against S*N + T*K.
   logic signed [L_BITS-1:0]        l_val;
   logic signed [K_BITS:0]          k_s;
   logic signed [NW:0]              n_s;
   logic signed [L_BITS+K_BITS:0]   p_lk_ff;
   logic signed [SW+NW:0]           p_sn_ff;
   logic signed [SW+K_BITS:0]       p_tk_ff;
   logic signed [PW-1:0]            p_lkn_ff;
   logic signed [PW-1:0]            rhs_ff;
   logic                            bit_val;

   // The stored pixel at the queried position, doubled and centered.
   assign l_val = L_BITS'({pix_rd_ff, 1'b0}) - L_BITS'(2 * PIX_CENTER);
   assign k_s   = (K_BITS+1)'(k_ff);
   assign n_s   = (NW+1)'(n_ff);

   always_ff @(posedge clock) begin
      if (ctrl.mul1) begin
         p_lk_ff <= l_val * k_s;
         p_sn_ff <= acc_ff * n_s;
         p_tk_ff <= total_ff * k_s;
      end
      if (ctrl.mul2) begin
         p_lkn_ff <= p_lk_ff * n_s;
         rhs_ff   <= PW'(p_sn_ff) + PW'(p_tk_ff);
      end
   end

   always_comb begin
      if (cfg.compare_mode == MODE_AT_OR_BELOW) begin
         bit_val = (p_lkn_ff <= rhs_ff);
      end else begin
         bit_val = (p_lkn_ff >= rhs_ff);
      end
   end

   // Result strobe register.
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.emit || ctrl.emit_default;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit_default) begin
         rsp_ff.bit_res   <= 1'b1;
         rsp_ff.in_region <= 1'b0;
      end else if (ctrl.emit) begin
         rsp_ff.bit_res   <= bit_val;
         rsp_ff.in_region <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== design/integral_image_adaptive_threshold_top.sv =====
// Adaptive threshold over a summed-area table. Frames are loaded one pixel per
// transaction in raster order; a query transaction then returns one bit for
// one pixel, comparing it against the average of its local window mean and
// the frame mean, exactly and without rounding. A transaction is accepted on
// a rising edge with start high and busy low. Each query produces exactly one
// result, shown on rsp_data for a single cycle with rsp_valid high; the
// receiver cannot stall it and must take it in that cycle. A load reads the
// row above from the summed-area memory, then writes the new entry (none when
// the load falls past the frame end); a query outside the valid window region
// returns a default result without reading memory, and a query inside the
// region reads the four window corners through the single read port of the
// summed-area memory, then passes the two registered multiply stages of the
// exact compare. There is no clearing pass after reset; queries are
// meaningful only after a full frame has been loaded.
`include "integral_image_adaptive_threshold_top_macros.svh"
`default_nettype none

module integral_image_adaptive_threshold_top
   import iiat_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  req_type                       req_data,
   output logic                          rsp_valid,
   output rsp_type                       rsp_data,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type    cfg;
   ctrl_type   ctrl;
   status_type status;

   // Configuration registers; the user must write them only while the block is idle, as the block does not enforce it.
   iiat_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The controller sequences loads and queries through the datapath.
   iiat_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .cmd    (req_data.cmd),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   // The datapath holds the frame memories, the running sums and the compare.
   iiat_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .ctrl      (ctrl),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // A result always follows a cycle in which the block was working.
   `IIAT_ASSERT_IMPLY(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))
   // Results never come in two consecutive cycles.
   `IIAT_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   // A load transaction produces no result.
   `IIAT_ASSERT_NEXT(a_load_silent, clock, reset, start && !busy && req_data.cmd == CMD_LOAD, !rsp_valid)
   // A pixel outside the processed region always reads as one.
   `IIAT_ASSERT_IMPLY(a_default_bit, clock, reset, rsp_valid && !rsp_data.in_region, rsp_data.bit_res)

endmodule

`default_nettype wire
